### rtl/rsc_pkg.sv
package rsc_pkg;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_SCANNING    = 3'd1,
    PH_WAIT_TIME   = 3'd2,
    PH_WAIT_LOST   = 3'd3,
    PH_WAIT_RECALL = 3'd4,
    PH_SEEK_STOP   = 3'd5
  } phase_t;

  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_STOP  = 3'd2;
  localparam logic [2:0] ACT_UP    = 3'd3;
  localparam logic [2:0] ACT_DOWN  = 3'd4;

  localparam logic [1:0] MODE_TIMED   = 2'd0;
  localparam logic [1:0] MODE_CARRIER = 2'd1;
  localparam logic [1:0] MODE_SEEK    = 2'd2;

  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_UP   = 2'd1;
  localparam logic [1:0] STEP_DOWN = 2'd2;

  localparam logic [1:0] REG_SCAN_MODE = 2'd0;
  localparam logic [1:0] REG_LOST_HOLD = 2'd1;
  localparam logic [1:0] REG_FIND_HOLD = 2'd2;

  localparam logic [1:0] SQ_DEBOUNCE = 2'd3;
  localparam logic [7:0] STEP_DWELL  = 8'd2;
  localparam logic [7:0] START_DWELL = 8'd4;
  localparam logic [7:0] HOLD_RESET  = 8'd10;

  typedef struct packed {
    logic [2:0] action;
    logic       squelch_open;
    logic       channel_mode;
    logic       have_scan_list;
  } item_t;

  typedef struct packed {
    logic [1:0] step_cmd;
    logic       step_on_channel;
    logic       scan_active;
    logic       start_refused;
    logic       recall_channel;
  } result_t;

  typedef struct packed {
    logic [1:0] scan_mode;
    logic [7:0] lost_hold_ticks;
    logic [7:0] find_hold_ticks;
  } cfg_t;

endpackage

### rtl/radio_scan_controller_top.sv
// An accepted word is held in the input register and its result in the result register.
// One word per cycle while result_stall does not hold the output; the scan state updates
// in a single pass between the input register and the result register.
// Reset (synchronous, rst high): not scanning, idle, dwell 0, direction up,
// squelch count 0, scan mode timed, both hold times 10 ticks.
module radio_scan_controller_top
  import rsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_q_valid;
  logic    advance;
  result_t core_result;

  assign advance    = item_q_valid && (!result_valid || !result_stall);
  assign item_stall = item_q_valid && !advance;

  rsc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rsc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (item_q),
    .cfg    (cfg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_q_valid <= 1'b1;
    end else if (advance) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_result;
    end
  end

endmodule

### rtl/rsc_cfg.sv
module rsc_cfg
  import rsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output cfg_t       cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_mode       <= MODE_TIMED;
      cfg.lost_hold_ticks <= HOLD_RESET;
      cfg.find_hold_ticks <= HOLD_RESET;
    end else if (cfg_valid) begin
      // index 3 is not a register; the write is dropped
      unique case (cfg_index)
        REG_SCAN_MODE: cfg.scan_mode       <= cfg_data[1:0];
        REG_LOST_HOLD: cfg.lost_hold_ticks <= cfg_data;
        REG_FIND_HOLD: cfg.find_hold_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/rsc_core.sv
module rsc_core
  import rsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic       scan_on, scan_on_next;
  phase_t     scan_phase, scan_phase_next;
  logic [7:0] dwell_timer, dwell_timer_next;
  logic       scan_dir_down, scan_dir_down_next;
  logic [1:0] squelch_count, squelch_count_next;
  logic [7:0] dwell_dec;
  logic       try_step;

  assign dwell_dec = (dwell_timer != 8'd0) ? dwell_timer - 8'd1 : dwell_timer;

  always_comb begin
    scan_on_next       = scan_on;
    scan_phase_next    = scan_phase;
    dwell_timer_next   = dwell_timer;
    scan_dir_down_next = scan_dir_down;
    squelch_count_next = squelch_count;
    try_step           = 1'b0;
    result             = '0;

    unique case (item.action)
      ACT_TICK: begin
        dwell_timer_next = dwell_dec;
        if (scan_on) begin
          unique case (scan_phase)
            PH_SCANNING: begin
              if (item.squelch_open) begin
                if (squelch_count != SQ_DEBOUNCE) begin
                  squelch_count_next = squelch_count + 2'd1;
                end else if (cfg.scan_mode == MODE_TIMED) begin
                  scan_phase_next  = PH_WAIT_TIME;
                  dwell_timer_next = cfg.lost_hold_ticks;
                end else if (cfg.scan_mode == MODE_CARRIER) begin
                  scan_phase_next  = PH_WAIT_LOST;
                  dwell_timer_next = cfg.lost_hold_ticks;
                end else if (cfg.scan_mode == MODE_SEEK) begin
                  scan_phase_next  = PH_SEEK_STOP;
                  dwell_timer_next = cfg.find_hold_ticks;
                end
              end else begin
                try_step           = 1'b1;
                squelch_count_next = 2'd0;
              end
            end
            PH_WAIT_TIME, PH_WAIT_RECALL: begin
              try_step           = 1'b1;
              squelch_count_next = 2'd0;
            end
            PH_WAIT_LOST: begin
              if (item.squelch_open) begin
                dwell_timer_next = cfg.lost_hold_ticks;
              end else if (dwell_dec == 8'd0) begin
                scan_phase_next = PH_WAIT_RECALL;
              end
            end
            PH_SEEK_STOP: begin
              scan_phase_next       = PH_IDLE;
              dwell_timer_next      = 8'd0;
              scan_on_next          = 1'b0;
              squelch_count_next    = 2'd0;
              result.recall_channel = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ACT_START: begin
        if (item.channel_mode && !item.have_scan_list) begin
          result.start_refused = 1'b1;
        end else begin
          // start dwell is nonzero, so no step is taken here
          scan_on_next       = 1'b1;
          scan_phase_next    = PH_SCANNING;
          dwell_timer_next   = START_DWELL;
          scan_dir_down_next = 1'b0;
        end
      end
      ACT_STOP: begin
        scan_phase_next  = PH_IDLE;
        dwell_timer_next = 8'd0;
        scan_on_next     = 1'b0;
      end
      ACT_UP, ACT_DOWN: begin
        if (scan_on) begin
          scan_dir_down_next = (item.action == ACT_DOWN);
          dwell_timer_next   = 8'd0;
          try_step           = 1'b1;
        end
      end
      default: ;
    endcase

    if (try_step && dwell_timer_next == 8'd0) begin
      result.step_cmd        = scan_dir_down_next ? STEP_DOWN : STEP_UP;
      result.step_on_channel = item.channel_mode;
      scan_phase_next        = PH_SCANNING;
      dwell_timer_next       = STEP_DWELL;
    end

    result.scan_active = scan_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_on       <= 1'b0;
      scan_phase    <= PH_IDLE;
      dwell_timer   <= 8'd0;
      scan_dir_down <= 1'b0;
      squelch_count <= 2'd0;
    end else if (fire) begin
      scan_on       <= scan_on_next;
      scan_phase    <= scan_phase_next;
      dwell_timer   <= dwell_timer_next;
      scan_dir_down <= scan_dir_down_next;
      squelch_count <= squelch_count_next;
    end
  end

endmodule
